>>> design/ksrmq_pkg.sv
package ksrmq_pkg;

    // Command codes carried on the command field.
    localparam logic [1:0] CMD_FIND   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_RANGE  = 2'd3;

    // Width of a stored priority.
    localparam int unsigned PRIO_BITS = 31;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RESP
    } state_t;

endpackage

>>> design/keyed_store_range_max_query_top.sv
// Keyed store with range-maximum query.
// The input channel (s_*) takes one command per transfer: find, insert or
// update, delete, or range maximum over keys in [s_key, s_range_end).
// Keys are compared as signed values.
// The result channel (m_*) gives exactly one result per command. Fields
// that do not belong to the command are zero.
// Every command reads all CAPACITY entries of the entry memory, one per
// cycle, through its single read port. An insert or a delete is then
// written back at most once, and the result is loaded into the output
// register. m_valid and s_ready both rise when the result is loaded, so a
// new command is taken only after the result of the last one is in the
// output register.
// The output register parts the two sides: a stalled receiver holds the
// result and the block still takes the next command. A finished command
// waits only while an older result is still not taken.
// After reset the block clears all CAPACITY entries, one per cycle, and
// keeps s_ready low while it does so. The store is then empty.
// An insert of a new key into a full store changes nothing and reports
// m_status high.
module keyed_store_range_max_query_top
    import ksrmq_pkg::*;
#(
    parameter int unsigned CAPACITY = 64,
    parameter int unsigned KEY_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_command,
    input  logic signed [KEY_BITS-1:0] s_key,
    input  logic [PRIO_BITS-1:0]       s_priority_req,
    input  logic signed [KEY_BITS-1:0] s_range_end,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_found,
    output logic [PRIO_BITS-1:0]       m_range_max,
    output logic                       m_status
);

    localparam int unsigned ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
    localparam int unsigned ENTRY_W = 1 + KEY_BITS + PRIO_BITS;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CAPACITY);

    // Entry memory: {valid, key, priority}.
    logic [ENTRY_W-1:0] mem [CAPACITY];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // Control registers.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               m_valid_reg, m_valid_next;

    // Command and scan result registers.
    logic [1:0]                 cmd_reg, cmd_next;
    logic signed [KEY_BITS-1:0] key_reg, key_next;
    logic [PRIO_BITS-1:0]       prio_reg, prio_next;
    logic signed [KEY_BITS-1:0] end_reg, end_next;
    logic [ADDR_W-1:0]          rd_idx_reg, rd_idx_next;
    logic                       match_reg, match_next;
    logic [ADDR_W-1:0]          match_idx_reg, match_idx_next;
    logic                       free_reg, free_next;
    logic [ADDR_W-1:0]          free_idx_reg, free_idx_next;
    logic [PRIO_BITS-1:0]       max_reg, max_next;
    logic                       m_found_reg, m_found_next;
    logic [PRIO_BITS-1:0]       m_range_max_reg, m_range_max_next;
    logic                       m_status_reg, m_status_next;

    // The result fields are staged in ST_WRITE, so that an older result still
    // waiting in the output register keeps its payload.
    logic                       stg_found_reg, stg_found_next;
    logic [PRIO_BITS-1:0]       stg_range_max_reg, stg_range_max_next;
    logic                       stg_status_reg, stg_status_next;

    // Fields of the entry returned by the memory.
    logic                       ent_valid;
    logic signed [KEY_BITS-1:0] ent_key;
    logic [PRIO_BITS-1:0]       ent_prio;
    logic                       out_free;

    assign ent_valid = rd_data_reg[ENTRY_W-1];
    assign ent_key   = rd_data_reg[ENTRY_W-2 -: KEY_BITS];
    assign ent_prio  = rd_data_reg[PRIO_BITS-1:0];
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_found     = m_found_reg;
    assign m_range_max = m_range_max_reg;
    assign m_status    = m_status_reg;

    // Synchronous memory with one read and one write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and scan registers.
    always_ff @(posedge aclk) begin
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        prio_reg        <= prio_next;
        end_reg         <= end_next;
        rd_idx_reg      <= rd_idx_next;
        match_reg       <= match_next;
        match_idx_reg   <= match_idx_next;
        free_reg        <= free_next;
        free_idx_reg    <= free_idx_next;
        max_reg         <= max_next;
        m_found_reg     <= m_found_next;
        m_range_max_reg <= m_range_max_next;
        m_status_reg    <= m_status_next;
    end

    // Staged result registers.
    always_ff @(posedge aclk) begin
        stg_found_reg     <= stg_found_next;
        stg_range_max_reg <= stg_range_max_next;
        stg_status_reg    <= stg_status_next;
    end

    // Next state, scan datapath and memory control.
    always_comb begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        rd_pend_next       = 1'b0;
        m_valid_next       = m_valid_reg && !m_ready;
        cmd_next           = cmd_reg;
        key_next           = key_reg;
        prio_next          = prio_reg;
        end_next           = end_reg;
        rd_idx_next        = rd_idx_reg;
        match_next         = match_reg;
        match_idx_next     = match_idx_reg;
        free_next          = free_reg;
        free_idx_next      = free_idx_reg;
        max_next           = max_reg;
        m_found_next       = m_found_reg;
        m_range_max_next   = m_range_max_reg;
        m_status_next      = m_status_reg;
        stg_found_next     = stg_found_reg;
        stg_range_max_next = stg_range_max_reg;
        stg_status_next    = stg_status_reg;
        rd_en              = 1'b0;
        rd_addr            = cnt_reg[ADDR_W-1:0];
        wr_en              = 1'b0;
        wr_addr            = cnt_reg[ADDR_W-1:0];
        wr_data            = '0;

        case (state_reg)
            ST_CLEAR: begin
                // Write an empty entry at each address once after reset.
                wr_en = 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                // Capture the command and start a fresh scan.
                if (s_valid) begin
                    cmd_next   = s_command;
                    key_next   = s_key;
                    prio_next  = s_priority_req;
                    end_next   = s_range_end;
                    cnt_next   = '0;
                    match_next = 1'b0;
                    free_next  = 1'b0;
                    max_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle.
                if (cnt_reg != CNT_END) begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = cnt_reg[ADDR_W-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                // Examine the entry read in the previous cycle.
                if (rd_pend_reg) begin
                    if (ent_valid && ent_key == key_reg) begin
                        match_next     = 1'b1;
                        match_idx_next = rd_idx_reg;
                    end
                    if (!ent_valid && !free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                    if (cmd_reg == CMD_RANGE && ent_valid && ent_key >= key_reg
                            && ent_key < end_reg && ent_prio > max_reg) begin
                        max_next = ent_prio;
                    end
                    if (cnt_reg == CNT_END) begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                // Write back an insert or a delete and stage the result.
                if (cmd_reg == CMD_INSERT) begin
                    wr_data = {1'b1, key_reg, prio_reg};
                    if (match_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = match_idx_reg;
                    end else if (free_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = free_idx_reg;
                    end
                end else if (cmd_reg == CMD_DELETE) begin
                    wr_data = {1'b0, key_reg, prio_reg};
                    wr_en   = match_reg;
                    wr_addr = match_idx_reg;
                end
                stg_found_next     = (cmd_reg == CMD_FIND) && match_reg;
                stg_range_max_next = (cmd_reg == CMD_RANGE) ? max_reg : '0;
                stg_status_next    = (cmd_reg == CMD_INSERT) && !match_reg && !free_reg;
                state_next         = ST_RESP;
            end
            ST_RESP: begin
                // Load the result once the output register is free.
                if (out_free) begin
                    m_found_next     = stg_found_reg;
                    m_range_max_next = stg_range_max_reg;
                    m_status_next    = stg_status_reg;
                    m_valid_next     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
